>>> rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Field widths, result kinds and configuration register indexes shared by the
// segment intersection unit and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

    localparam int FIELD_W = 16;
    localparam int TOL_W   = 32;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam int PT_MAX = 32767;
    localparam int PT_MIN = -32768;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_kind KIND_NONE  = 3'd0;
    localparam t_kind KIND_C     = 3'd1;
    localparam t_kind KIND_D     = 3'd2;
    localparam t_kind KIND_A     = 3'd3;
    localparam t_kind KIND_B     = 3'd4;
    localparam t_kind KIND_CROSS = 3'd5;

    localparam t_cfg_idx CFG_ORIENT_TOL = 1'b0;
    localparam t_cfg_idx CFG_COLL_TOL   = 1'b1;

endpackage

`default_nettype wire

>>> rtl/sgi_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Two numerator lanes share one divisor; one quotient bit is resolved in each
// register stage, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_div
    import sgi_pkg::*;
#(
    parameter int NUM_W = 52,
    parameter int DEN_W = 35,
    parameter int QUO_W = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num_x,
    input  wire logic [NUM_W-1:0] i_num_y,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo_x,
    output logic [QUO_W-1:0]      o_quo_y
);

    localparam int CPW = NUM_W + QUO_W;

    logic [NUM_W-1:0] r_rx [0:QUO_W];
    logic [NUM_W-1:0] r_ry [0:QUO_W];
    logic [DEN_W-1:0] r_d  [0:QUO_W];
    logic [QUO_W-1:0] r_qx [0:QUO_W];
    logic [QUO_W-1:0] r_qy [0:QUO_W];
    logic [QUO_W:0]   r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rx[0] <= i_num_x;
        r_ry[0] <= i_num_y;
        r_d[0]  <= i_den;
        r_qx[0] <= '0;
        r_qy[0] <= '0;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int J = QUO_W - 1 - k;

        logic [CPW-1:0] dsh;
        logic           gex;
        logic           gey;
        logic [NUM_W-1:0] n_rx;
        logic [NUM_W-1:0] n_ry;

        always_comb begin
            dsh  = CPW'(r_d[k]) << J;
            gex  = CPW'(r_rx[k]) >= dsh;
            gey  = CPW'(r_ry[k]) >= dsh;
            n_rx = gex ? NUM_W'(CPW'(r_rx[k]) - dsh) : r_rx[k];
            n_ry = gey ? NUM_W'(CPW'(r_ry[k]) - dsh) : r_ry[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rx[k+1] <= n_rx;
            r_ry[k+1] <= n_ry;
            r_d[k+1]  <= r_d[k];
            r_qx[k+1] <= r_qx[k] | (QUO_W'(gex) << J);
            r_qy[k+1] <= r_qy[k] | (QUO_W'(gey) << J);
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo_x = r_qx[QUO_W];
    assign o_quo_y = r_qy[QUO_W];

endmodule

`default_nettype wire

>>> rtl/segment_intersection_2d_unit.sv
// ----------------------------------------------------------------------------
// Segment intersection unit
// Tests two segments AB and CD for a touching endpoint or a crossing point.
//
// A transaction is started by raising start for one cycle with the eight
// Q8.8 coordinates on their ports; busy is always low, so a new transaction
// may start in every cycle. Each transaction gives one result, shown for one
// cycle with o_done high: o_hit, o_point_x, o_point_y and o_hit_kind.
// Coordinate widths are clamped to 2..19. The restoring divider resolves
// one quotient bit per stage. Throughput is one transaction per cycle.
// The receiver cannot stall the unit; results leave in the order the
// transactions arrived.
// The two tolerance registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while no transaction is in
// flight, which the unit itself does not enforce. Synchronous reset
// clears both tolerances to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_2d_unit
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_ax,
    input  wire logic signed [15:0] i_ay,
    input  wire logic signed [15:0] i_bx,
    input  wire logic signed [15:0] i_by,
    input  wire logic signed [15:0] i_cx,
    input  wire logic signed [15:0] i_cy,
    input  wire logic signed [15:0] i_dx,
    input  wire logic signed [15:0] i_dy,
    input  wire logic               i_cfg_we,
    input  wire t_cfg_idx           i_cfg_idx,
    input  wire logic [TOL_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic                    o_hit,
    output logic signed [15:0]      o_point_x,
    output logic signed [15:0]      o_point_y,
    output t_kind                   o_hit_kind
);

    localparam int CW   = (COORD_WIDTH < 2) ? 2 : ((COORD_WIDTH > 19) ? 19 : COORD_WIDTH);
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int LB   = XW / 2;
    localparam int HB   = XW - LB;
    localparam int PLW  = DW + LB + 1;
    localparam int PHW  = DW + HB;
    localparam int NW   = DW + XW;
    localparam int QW   = (CW + 1 > 17) ? CW + 1 : 17;
    localparam int FW   = ((CW > QW) ? CW : QW) + 2;
    localparam int CMPW = (XW > TOL_W) ? XW : TOL_W;
    localparam int OVW  = NW + QW;

    localparam int DIF_P [12] = '{2, 3, 6, 7, 4, 5, 6, 7, 0, 1, 2, 3};
    localparam int DIF_M [12] = '{0, 1, 4, 5, 0, 1, 0, 1, 4, 5, 4, 5};
    localparam int MUL_L [24] = '{0, 1, 0, 1, 2, 3, 2, 3, 4, 5, 6, 7,
                                  0, 1, 8, 9, 10, 11, 2, 3, 0, 1, 4, 5};
    localparam int MUL_R [24] = '{5, 4, 7, 6, 9, 8, 11, 10, 0, 1, 0, 1,
                                  0, 1, 2, 3, 2, 3, 2, 3, 3, 2, 3, 2};
    localparam logic [11:0] SUB_MASK = 12'b1100_0000_1111;

    typedef struct packed {
        t_kind                kind;
        logic signed [15:0]   ptx;
        logic signed [15:0]   pty;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic                 sx;
        logic                 sy;
        logic                 ox;
        logic                 oy;
    } t_side;

    function automatic logic [15:0] sat_pt(input logic signed [FW-1:0] v);
        logic [15:0] r;
        if (v > FW'(PT_MAX)) begin
            r = 16'(PT_MAX);
        end else if (v < FW'(PT_MIN)) begin
            r = 16'(PT_MIN);
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
        return v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    logic [TOL_W-1:0] r_orient_tol;
    logic [TOL_W-1:0] r_coll_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient_tol <= '0;
            r_coll_tol   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIENT_TOL: r_orient_tol <= i_cfg_data;
                CFG_COLL_TOL:   r_coll_tol   <= i_cfg_data;
                default:        r_coll_tol   <= r_coll_tol;
            endcase
        end
    end

    assign busy = 1'b0;

    logic signed [15:0]   in_raw [0:7];
    logic signed [CW-1:0] in_ext [0:7];

    assign in_raw[0] = i_ax;
    assign in_raw[1] = i_ay;
    assign in_raw[2] = i_bx;
    assign in_raw[3] = i_by;
    assign in_raw[4] = i_cx;
    assign in_raw[5] = i_cy;
    assign in_raw[6] = i_dx;
    assign in_raw[7] = i_dy;

    for (genvar g = 0; g < 8; g++) begin : g_ext
        if (CW <= FIELD_W) begin : g_narrow
            assign in_ext[g] = in_raw[g][CW-1:0];
        end else begin : g_wide
            assign in_ext[g] = {{(CW - FIELD_W){1'b0}}, in_raw[g]};
        end
    end

    logic [7:1] r_v;

    logic signed [CW-1:0] r1_c [0:7];
    logic signed [CW-1:0] r2_c [0:7];
    logic signed [DW-1:0] r2_d [0:11];
    logic signed [CW-1:0] r3_c [0:7];
    logic signed [DW-1:0] r3_ab [0:1];
    logic signed [PW-1:0] r3_m [0:23];
    logic signed [CW-1:0] r4_c [0:7];
    logic signed [DW-1:0] r4_ab [0:1];
    logic signed [XW-1:0] r4_s [0:11];

    logic signed [DW-1:0] n2_d [0:11];
    logic signed [PW-1:0] n3_m [0:23];
    logic signed [XW-1:0] n4_s [0:11];

    always_comb begin
        for (int k = 0; k < 12; k++) begin
            n2_d[k] = DW'(r1_c[DIF_P[k]]) - DW'(r1_c[DIF_M[k]]);
        end
        for (int k = 0; k < 24; k++) begin
            n3_m[k] = PW'(r2_d[MUL_L[k]]) * PW'(r2_d[MUL_R[k]]);
        end
        for (int k = 0; k < 12; k++) begin
            if (SUB_MASK[k]) begin
                n4_s[k] = XW'(r3_m[2*k]) - XW'(r3_m[2*k+1]);
            end else begin
                n4_s[k] = XW'(r3_m[2*k]) + XW'(r3_m[2*k+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:1], start};
        end
        r1_c  <= in_ext;
        r2_c  <= r1_c;
        r2_d  <= n2_d;
        r3_c  <= r2_c;
        r3_ab <= r2_d[0:1];
        r3_m  <= n3_m;
        r4_c  <= r3_c;
        r4_ab <= r3_ab;
        r4_s  <= n4_s;
    end

    t_kind              n5_kind;
    logic signed [15:0] n5_ptx;
    logic signed [15:0] n5_pty;
    logic signed [PLW-1:0] n5_plx;
    logic signed [PLW-1:0] n5_ply;
    logic signed [PHW-1:0] n5_phx;
    logic signed [PHW-1:0] n5_phy;

    logic z1, z2, z3, z4;
    logic on_c, on_d, on_a, on_b;
    logic decided;
    logic signed [LB:0]   num_lo;
    logic signed [HB-1:0] num_hi;

    always_comb begin
        z1 = CMPW'(mag_x(r4_s[0])) <= CMPW'(r_orient_tol);
        z2 = CMPW'(mag_x(r4_s[1])) <= CMPW'(r_orient_tol);
        z3 = CMPW'(mag_x(r4_s[2])) <= CMPW'(r_orient_tol);
        z4 = CMPW'(mag_x(r4_s[3])) <= CMPW'(r_orient_tol);
        on_c = (CMPW'(mag_x(r4_s[0])) <= CMPW'(r_coll_tol)) && !r4_s[4][XW-1]
            && (r4_s[4] <= r4_s[6]);
        on_d = (CMPW'(mag_x(r4_s[1])) <= CMPW'(r_coll_tol)) && !r4_s[5][XW-1]
            && (r4_s[5] <= r4_s[6]);
        on_a = (CMPW'(mag_x(r4_s[2])) <= CMPW'(r_coll_tol)) && !r4_s[7][XW-1]
            && (r4_s[7] <= r4_s[9]);
        on_b = (CMPW'(mag_x(r4_s[3])) <= CMPW'(r_coll_tol)) && !r4_s[8][XW-1]
            && (r4_s[8] <= r4_s[9]);

        n5_kind = KIND_NONE;
        decided = 1'b0;
        if (z1 || z2) begin
            if (z1 && on_c) begin
                n5_kind = KIND_C;
                decided = 1'b1;
            end else if (z2 && on_d) begin
                n5_kind = KIND_D;
                decided = 1'b1;
            end
        end else if (r4_s[0][XW-1] == r4_s[1][XW-1]) begin
            decided = 1'b1;
        end
        if (!decided) begin
            if (z3 || z4) begin
                if (z3 && on_a) begin
                    n5_kind = KIND_A;
                    decided = 1'b1;
                end else if (z4 && on_b) begin
                    n5_kind = KIND_B;
                    decided = 1'b1;
                end
            end else if (r4_s[2][XW-1] == r4_s[3][XW-1]) begin
                decided = 1'b1;
            end
        end
        if (!decided && (CMPW'(mag_x(r4_s[10])) > CMPW'(r_coll_tol))) begin
            n5_kind = KIND_CROSS;
        end

        case (n5_kind)
            KIND_C: begin
                n5_ptx = sat_pt(FW'(r4_c[4]));
                n5_pty = sat_pt(FW'(r4_c[5]));
            end
            KIND_D: begin
                n5_ptx = sat_pt(FW'(r4_c[6]));
                n5_pty = sat_pt(FW'(r4_c[7]));
            end
            KIND_A: begin
                n5_ptx = sat_pt(FW'(r4_c[0]));
                n5_pty = sat_pt(FW'(r4_c[1]));
            end
            KIND_B: begin
                n5_ptx = sat_pt(FW'(r4_c[2]));
                n5_pty = sat_pt(FW'(r4_c[3]));
            end
            default: begin
                n5_ptx = '0;
                n5_pty = '0;
            end
        endcase

        num_lo = $signed({1'b0, r4_s[11][LB-1:0]});
        num_hi = r4_s[11][XW-1:LB];
        n5_plx = PLW'(r4_ab[0]) * PLW'(num_lo);
        n5_ply = PLW'(r4_ab[1]) * PLW'(num_lo);
        n5_phx = PHW'(r4_ab[0]) * PHW'(num_hi);
        n5_phy = PHW'(r4_ab[1]) * PHW'(num_hi);
    end

    t_kind                 r5_kind, r6_kind, r7_kind;
    logic signed [15:0]    r5_ptx, r5_pty, r6_ptx, r6_pty, r7_ptx, r7_pty;
    logic signed [CW-1:0]  r5_ax, r5_ay, r6_ax, r6_ay, r7_ax, r7_ay;
    logic signed [XW-1:0]  r5_den, r6_den;
    logic signed [PLW-1:0] r5_plx, r5_ply;
    logic signed [PHW-1:0] r5_phx, r5_phy;
    logic signed [NW-1:0]  r6_nx, r6_ny;
    logic [NW-1:0]         r7_anx, r7_any;
    logic [XW-1:0]         r7_ad;
    logic                  r7_sx, r7_sy;

    always_ff @(posedge i_clk) begin
        r5_kind <= n5_kind;
        r5_ptx  <= n5_ptx;
        r5_pty  <= n5_pty;
        r5_ax   <= r4_c[0];
        r5_ay   <= r4_c[1];
        r5_den  <= r4_s[10];
        r5_plx  <= n5_plx;
        r5_ply  <= n5_ply;
        r5_phx  <= n5_phx;
        r5_phy  <= n5_phy;

        r6_kind <= r5_kind;
        r6_ptx  <= r5_ptx;
        r6_pty  <= r5_pty;
        r6_ax   <= r5_ax;
        r6_ay   <= r5_ay;
        r6_den  <= r5_den;
        r6_nx   <= (NW'(r5_phx) <<< LB) + NW'(r5_plx);
        r6_ny   <= (NW'(r5_phy) <<< LB) + NW'(r5_ply);

        r7_kind <= r6_kind;
        r7_ptx  <= r6_ptx;
        r7_pty  <= r6_pty;
        r7_ax   <= r6_ax;
        r7_ay   <= r6_ay;
        r7_anx  <= r6_nx[NW-1] ? NW'(-r6_nx) : NW'(r6_nx);
        r7_any  <= r6_ny[NW-1] ? NW'(-r6_ny) : NW'(r6_ny);
        r7_ad   <= mag_x(r6_den);
        r7_sx   <= r6_nx[NW-1] ^ r6_den[XW-1];
        r7_sy   <= r6_ny[NW-1] ^ r6_den[XW-1];
    end

    logic          div_valid;
    logic [QW-1:0] div_qx;
    logic [QW-1:0] div_qy;

    sgi_div #(
        .NUM_W(NW),
        .DEN_W(XW),
        .QUO_W(QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[7]),
        .i_num_x (r7_anx),
        .i_num_y (r7_any),
        .i_den   (r7_ad),
        .o_valid (div_valid),
        .o_quo_x (div_qx),
        .o_quo_y (div_qy)
    );

    t_side r_sb [0:QW];
    t_side n_sb;

    always_comb begin
        n_sb.kind = r7_kind;
        n_sb.ptx  = r7_ptx;
        n_sb.pty  = r7_pty;
        n_sb.ax   = r7_ax;
        n_sb.ay   = r7_ay;
        n_sb.sx   = r7_sx;
        n_sb.sy   = r7_sy;
        n_sb.ox   = OVW'(r7_anx) >= (OVW'(r7_ad) << QW);
        n_sb.oy   = OVW'(r7_any) >= (OVW'(r7_ad) << QW);
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_sb;
        for (int k = 0; k < QW; k++) begin
            r_sb[k+1] <= r_sb[k];
        end
    end

    t_side                side;
    logic signed [FW-1:0] sqx, sqy;
    logic signed [15:0]   crx, cry;
    logic signed [15:0]   n_px, n_py;

    always_comb begin
        side = r_sb[QW];
        sqx  = side.sx ? -$signed(FW'(div_qx)) : $signed(FW'(div_qx));
        sqy  = side.sy ? -$signed(FW'(div_qy)) : $signed(FW'(div_qy));
        if (side.ox) begin
            crx = side.sx ? 16'(PT_MIN) : 16'(PT_MAX);
        end else begin
            crx = sat_pt(FW'(side.ax) + sqx);
        end
        if (side.oy) begin
            cry = side.sy ? 16'(PT_MIN) : 16'(PT_MAX);
        end else begin
            cry = sat_pt(FW'(side.ay) + sqy);
        end
        if (side.kind == KIND_CROSS) begin
            n_px = crx;
            n_py = cry;
        end else begin
            n_px = side.ptx;
            n_py = side.pty;
        end
    end

    logic               r_done;
    logic               r_hit;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    t_kind              r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_valid;
        end
        r_hit  <= side.kind != KIND_NONE;
        r_px   <= n_px;
        r_py   <= n_py;
        r_kind <= side.kind;
    end

    assign o_done     = r_done;
    assign o_hit      = r_hit;
    assign o_point_x  = r_px;
    assign o_point_y  = r_py;
    assign o_hit_kind = r_kind;

endmodule

`default_nettype wire
